FILE: rtl/uartrx_pkg.sv
// Shared types, constants and helpers for the UART receive FIFO event logic.
package uartrx_pkg;

    localparam int FIFO_DEPTH = 256;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int BYTE_W     = 8;
    localparam int RC_W       = 9;
    localparam int THR_W      = 9;
    localparam int FILL_W     = 9;
    // common width for level compares against 9-bit counts and thresholds
    localparam int CMP_W      = (CNT_W > RC_W) ? CNT_W : RC_W;

    typedef enum logic [1:0] {
        CMD_RX      = 2'd0,
        CMD_ARM     = 2'd1,
        CMD_POP     = 2'd2,
        CMD_NEWLINE = 2'd3
    } t_cmd;

    localparam logic CFG_WATCH_CHAR = 1'b0;
    localparam logic CFG_BYTES_THR  = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] watch_char;
        logic [THR_W-1:0]  bytes_threshold;
    } t_cfg;

    typedef struct packed {
        logic              read_done_event;
        logic              data_event;
        logic              data_kind;
        logic              dropped;
        logic              pop_valid;
        logic [BYTE_W-1:0] pop_data;
        logic [FILL_W-1:0] fill_level;
    } t_res;

    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [PTR_W-1:0]  raddr;
    } t_ram_req;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

endpackage

FILE: rtl/uart_rx_fifo_event_logic.sv
// Top level: config registers, receive FIFO storage and event control.
//
//  channel | direction | handshake               | beat contents
//  --------+-----------+-------------------------+-------------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_cmd, i_byte_value, i_read_count
//  out     | output    | o_out_valid/i_out_stall | events, dropped, pop_valid/data, fill_level
//  cfg     | input     | i_cfg_we                | i_cfg_index, i_cfg_wdata
//
// One beat per cycle for receive, arm, newline and empty pop while the input is not stalled;
// a pop from a non-empty FIFO stalls the input while the FIFO RAM's registered read returns.
// Reset is synchronous, active low; FIFO contents are not cleared, only pointers, level,
// armed read, newline char, pop state, valids and config. No clearing pass after reset.
// Input is taken while a result waits in the output register; a skid entry
// holds one more. The input stalls while that entry is full or a pop read is out.
module uart_rx_fifo_event_logic (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_cmd,
    input  logic [uartrx_pkg::BYTE_W-1:0] i_byte_value,
    input  logic [uartrx_pkg::RC_W-1:0]   i_read_count,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_read_done_event,
    output logic                          o_data_event,
    output logic                          o_data_kind,
    output logic                          o_dropped,
    output logic                          o_pop_valid,
    output logic [uartrx_pkg::BYTE_W-1:0] o_pop_data,
    output logic [uartrx_pkg::FILL_W-1:0] o_fill_level,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [uartrx_pkg::THR_W-1:0]  i_cfg_wdata
);

    uartrx_pkg::t_cfg                r_cfg;
    uartrx_pkg::t_ram_req            ram_req;
    uartrx_pkg::t_res                res;
    logic [uartrx_pkg::BYTE_W-1:0]   ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.watch_char      <= '0;
            r_cfg.bytes_threshold <= uartrx_pkg::THR_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                uartrx_pkg::CFG_WATCH_CHAR: begin
                    r_cfg.watch_char <= i_cfg_wdata[uartrx_pkg::BYTE_W-1:0];
                end
                uartrx_pkg::CFG_BYTES_THR: begin
                    r_cfg.bytes_threshold <= i_cfg_wdata;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    uartrx_ram #(
        .WIDTH (uartrx_pkg::BYTE_W),
        .DEPTH (uartrx_pkg::FIFO_DEPTH)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    uartrx_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_byte_value (i_byte_value),
        .i_read_count (i_read_count),
        .i_cfg        (r_cfg),
        .o_ram_req    (ram_req),
        .i_ram_rdata  (ram_rdata),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_res        (res)
    );

    assign o_read_done_event = res.read_done_event;
    assign o_data_event      = res.data_event;
    assign o_data_kind       = res.data_kind;
    assign o_dropped         = res.dropped;
    assign o_pop_valid       = res.pop_valid;
    assign o_pop_data        = res.pop_data;
    assign o_fill_level      = res.fill_level;

`ifndef NO_ASSERTIONS
    // a RAM read for a pop blocks the input while the data comes back
    a_pop_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_req.re |=> o_in_stall)
        else $error("input not stalled during pop read");

    // a pop beat carries no receive-side flags
    a_pop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pop_valid) |-> (!o_dropped && !o_read_done_event && !o_data_event))
        else $error("pop beat with receive flags");

    // read-done and data events never share a beat
    a_evt_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_read_done_event && o_data_event))
        else $error("read-done and data event together");

    // the data tag is only set with a data event
    a_kind_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_data_event) |-> !o_data_kind)
        else $error("data_kind set without data event");
`endif

endmodule

FILE: rtl/uartrx_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module uartrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/uartrx_core.sv
// FIFO pointer/level control, read-arm and event decisions, output register with skid.
module uartrx_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_cmd,
    input  logic [uartrx_pkg::BYTE_W-1:0]   i_byte_value,
    input  logic [uartrx_pkg::RC_W-1:0]     i_read_count,
    input  uartrx_pkg::t_cfg                i_cfg,
    output uartrx_pkg::t_ram_req            o_ram_req,
    input  logic [uartrx_pkg::BYTE_W-1:0]   i_ram_rdata,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output uartrx_pkg::t_res                o_res
);

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    t_state                              r_state, n_state;
    logic [uartrx_pkg::PTR_W-1:0]        r_head, n_head;
    logic [uartrx_pkg::PTR_W-1:0]        r_tail, n_tail;
    logic [uartrx_pkg::CNT_W-1:0]        r_fill, n_fill;
    logic [uartrx_pkg::RC_W-1:0]         r_pending, n_pending;
    logic [uartrx_pkg::BYTE_W-1:0]       r_newline, n_newline;
    logic                                r_out_valid, n_out_valid;
    logic                                r_skd_valid, n_skd_valid;
    uartrx_pkg::t_res                    r_out, n_out;
    uartrx_pkg::t_res                    r_skd, n_skd;

    uartrx_pkg::t_res                    res;
    logic                                res_valid;
    logic                                accept;
    logic                                out_take;
    logic [uartrx_pkg::CMP_W-1:0]        fill_ext;
    logic [uartrx_pkg::CMP_W-1:0]        n_fill_ext;

    assign o_in_stall = (r_state != S_IDLE) || r_skd_valid;
    assign accept     = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;
    assign fill_ext   = uartrx_pkg::CMP_W'(r_fill);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_fill    = r_fill;
        n_pending = r_pending;
        n_newline = r_newline;
        res       = '0;
        res_valid = 1'b0;
        o_ram_req = '0;
        o_ram_req.waddr = r_tail;
        o_ram_req.wdata = i_byte_value;
        o_ram_req.raddr = r_head;

        if (r_state == S_POP) begin
            // read data for the pop issued last cycle
            res_valid     = 1'b1;
            res.pop_valid = 1'b1;
            res.pop_data  = i_ram_rdata;
            n_state       = S_IDLE;
        end else if (accept) begin
            case (uartrx_pkg::t_cmd'(i_cmd))
                uartrx_pkg::CMD_RX: begin
                    res_valid = 1'b1;
                    if (r_fill == uartrx_pkg::CNT_W'(uartrx_pkg::FIFO_DEPTH)) begin
                        res.dropped = 1'b1;
                    end else begin
                        o_ram_req.we = 1'b1;
                        n_tail       = uartrx_pkg::next_ptr(r_tail);
                        n_fill       = r_fill + 1'b1;
                    end
                end
                uartrx_pkg::CMD_ARM: begin
                    res_valid = 1'b1;
                    if (fill_ext >= uartrx_pkg::CMP_W'(i_read_count)) begin
                        res.read_done_event = 1'b1;
                    end else begin
                        n_pending = i_read_count;
                    end
                end
                uartrx_pkg::CMD_POP: begin
                    if (r_fill != '0) begin
                        o_ram_req.re = 1'b1;
                        n_head       = uartrx_pkg::next_ptr(r_head);
                        n_fill       = r_fill - 1'b1;
                        n_state      = S_POP;
                    end else begin
                        res_valid = 1'b1;
                    end
                end
                uartrx_pkg::CMD_NEWLINE: begin
                    res_valid = 1'b1;
                    n_newline = i_byte_value;
                end
                default: begin
                    res_valid = 1'b1;
                end
            endcase
        end

        n_fill_ext = uartrx_pkg::CMP_W'(n_fill);

        // event decision for a received byte, on the level after the push
        if (accept && (uartrx_pkg::t_cmd'(i_cmd) == uartrx_pkg::CMD_RX)) begin
            if (r_pending != '0) begin
                if ((n_fill_ext >= uartrx_pkg::CMP_W'(r_pending)) ||
                    (i_byte_value == i_cfg.watch_char)) begin
                    n_pending           = '0;
                    res.read_done_event = 1'b1;
                end
            end else if ((r_newline != '0) && (i_byte_value == r_newline)) begin
                res.read_done_event = 1'b1;
            end else if (n_fill_ext >= uartrx_pkg::CMP_W'(i_cfg.bytes_threshold)) begin
                res.data_event = 1'b1;
                res.data_kind  = (i_byte_value == i_cfg.watch_char);
            end
        end

        res.fill_level = n_fill_ext[uartrx_pkg::FILL_W-1:0];
    end

    // output register plus one skid entry
    always_comb begin
        n_out       = r_out;
        n_skd       = r_skd;
        n_out_valid = r_out_valid && !out_take;
        n_skd_valid = r_skd_valid;
        if (r_skd_valid && out_take) begin
            n_out       = r_skd;
            n_out_valid = 1'b1;
            n_skd_valid = 1'b0;
        end
        if (res_valid) begin
            if (!n_out_valid) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_skd       = res;
                n_skd_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_pending   <= '0;
            r_newline   <= '0;
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_pending   <= n_pending;
            r_newline   <= n_newline;
            r_out_valid <= n_out_valid;
            r_skd_valid <= n_skd_valid;
        end
        r_out <= n_out;
        r_skd <= n_skd;
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

endmodule
